### src/assert_macros.svh
// Assertion macros used by the blur unit's top-level RTL file.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### src/gber_pkg.sv
// Package for the edge-renormalized blur unit: payload structs, opcodes,
// register indexes, defaults and the controller/datapath interface structs.
package gber_pkg;

    // Parameter defaults
    localparam int MAX_RADIUS_DEF  = 4;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int ROW_LIMIT       = 4096;

    // Operation codes
    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_PIXEL  = 2'd1;
    localparam logic [1:0] OP_DRAIN  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    localparam int CFG_DATA_W = 13;

    // Register reset values
    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [12:0] HEIGHT_RST = 13'd480;
    localparam logic [2:0]  RADIUS_RST = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  weight_index;
        logic [15:0] weight_value;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic [11:0] out_row;
        logic [9:0]  out_col;
        logic        frame_end;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic scan_init;
        logic scan_step;
        logic div_step;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic start_emit;
        logic scan_last;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

### src/gber_ctrl.sv
// Controller FSM for the blur unit: sequences accept, window scan,
// divide and result transfer. Depends on gber_pkg.
module gber_ctrl
    import gber_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_FLUSH = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept    = in_valid;
                cmd.scan_init = in_valid && status.start_emit;
                if (in_valid && status.start_emit)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                cmd.emit = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

### src/gber_dp.sv
// Datapath for the blur unit: config registers, weight table, line store,
// window scan, MAC, restoring divider and output register. Depends on gber_pkg.
module gber_dp
    import gber_pkg::*;
#(
    parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  in_item_t              in_data,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output status_t               status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    localparam int KDIM     = 2 * MAX_RADIUS + 1;
    localparam int KSIZE    = KDIM * KDIM;
    localparam int LS_DEPTH = KDIM * MAX_WIDTH;
    localparam int LA       = $clog2(LS_DEPTH);
    localparam int KA       = $clog2(KSIZE);
    localparam int KB       = $clog2(KDIM);
    localparam int WB       = $clog2(MAX_WIDTH + 1);
    localparam int RB       = $clog2(MAX_RADIUS + 1);
    localparam int PW       = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
    localparam int ACC_W    = 8 + WEIGHT_BITS + $clog2(KSIZE);
    localparam int SUM_W    = WEIGHT_BITS + $clog2(KSIZE);
    localparam int RW       = 14;
    localparam int CW       = WB + 2;
    localparam int PRW      = 8 + WEIGHT_BITS;

    // Configuration registers
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  radius_reg;
    logic        cfg_hit;

    assign cfg_hit = cfg_write &&
                     (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
                      cfg_index == CFG_RADIUS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            radius_reg <= RADIUS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data[10:0];
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_RADIUS: radius_reg <= cfg_data[2:0];
                default:    ;
            endcase
        end
    end

    // Effective (clamped) geometry
    logic [WB-1:0] w_eff;
    logic [12:0]   h_eff;
    logic [RB-1:0] r_eff;
    logic [KB-1:0] diam_m1;
    logic [PW-1:0] lag;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = WB'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            w_eff = WB'(MAX_WIDTH);
        else
            w_eff = WB'(width_reg);
        if (height_reg == '0)
            h_eff = 13'd1;
        else if (int'(height_reg) > ROW_LIMIT)
            h_eff = 13'(ROW_LIMIT);
        else
            h_eff = height_reg;
        if (int'(radius_reg) > MAX_RADIUS)
            r_eff = RB'(MAX_RADIUS);
        else
            r_eff = RB'(radius_reg);
    end

    assign diam_m1 = KB'({r_eff, 1'b0});
    assign lag     = PW'(PW'(r_eff) * PW'(w_eff)) + PW'(r_eff);

    // Stream counters
    logic [LA-1:0] wr_addr_reg;
    logic [LA-1:0] out_addr_reg;
    logic [WB-1:0] out_col_reg;
    logic [11:0]   out_row_reg;
    logic [PW-1:0] pending_reg;
    logic          is_pixel, is_weight, is_drain;

    assign is_pixel  = cmd.accept && (in_data.operation == OP_PIXEL);
    assign is_weight = cmd.accept && (in_data.operation == OP_WEIGHT);
    assign is_drain  = (in_data.operation == OP_DRAIN);

    always_comb
    begin
        status.start_emit = 1'b0;
        if (in_data.operation == OP_PIXEL)
            status.start_emit = (pending_reg + PW'(1)) > lag;
        else if (is_drain)
            status.start_emit = (pending_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_addr_reg  <= '0;
            out_addr_reg <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pending_reg  <= '0;
        end
        else if (cfg_hit)
        begin
            wr_addr_reg  <= '0;
            out_addr_reg <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            if (is_pixel)
            begin
                wr_addr_reg <= (int'(wr_addr_reg) == LS_DEPTH - 1) ? '0 : wr_addr_reg + LA'(1);
                pending_reg <= pending_reg + PW'(1);
            end
            if (cmd.emit)
            begin
                out_addr_reg <= (int'(out_addr_reg) == LS_DEPTH - 1) ?
                                '0 : out_addr_reg + LA'(1);
                pending_reg  <= pending_reg - PW'(1);
                if (out_col_reg + WB'(1) >= w_eff)
                begin
                    out_col_reg <= '0;
                    out_row_reg <= (13'(out_row_reg) + 13'd1 >= h_eff) ?
                                   '0 : out_row_reg + 12'd1;
                end
                else
                begin
                    out_col_reg <= out_col_reg + WB'(1);
                end
            end
        end
    end

    // Window scan registers
    logic [LA-1:0]        ptr_reg, row_ptr_reg;
    logic [KB-1:0]        dxi_reg, dyi_reg;
    logic [KA-1:0]        widx_reg;
    logic signed [RW-1:0] cur_row_reg;
    logic signed [CW-1:0] cur_col_reg;
    logic signed [CW-1:0] col_start;
    logic [LA:0]          base_sum, row_sum;
    logic [LA-1:0]        base_addr, next_row_ptr;
    logic                 in_frame, is_centre;

    assign col_start = CW'(out_col_reg) - CW'(r_eff);
    assign base_sum  = {1'b0, out_addr_reg} + (LA + 1)'(LS_DEPTH) - (LA + 1)'(lag);
    assign base_addr = (int'(base_sum) >= LS_DEPTH) ?
                       LA'(base_sum - (LA + 1)'(LS_DEPTH)) : LA'(base_sum);
    assign row_sum   = {1'b0, row_ptr_reg} + (LA + 1)'(w_eff);
    assign next_row_ptr = (int'(row_sum) >= LS_DEPTH) ?
                          LA'(row_sum - (LA + 1)'(LS_DEPTH)) : LA'(row_sum);

    assign in_frame  = !cur_row_reg[RW-1] && (cur_row_reg[12:0] < h_eff) &&
                       !cur_col_reg[CW-1] && (cur_col_reg[CW-2:0] < (CW - 1)'(w_eff));
    assign is_centre = (dxi_reg == KB'(r_eff)) && (dyi_reg == KB'(r_eff));
    assign status.scan_last = (dxi_reg == diam_m1) && (dyi_reg == diam_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg     <= '0;
            row_ptr_reg <= '0;
            dxi_reg     <= '0;
            dyi_reg     <= '0;
            widx_reg    <= '0;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            ptr_reg     <= base_addr;
            row_ptr_reg <= base_addr;
            dxi_reg     <= '0;
            dyi_reg     <= '0;
            widx_reg    <= '0;
            cur_row_reg <= RW'(out_row_reg) - RW'(r_eff);
            cur_col_reg <= col_start;
        end
        else if (cmd.scan_step)
        begin
            widx_reg <= widx_reg + KA'(1);
            if (dxi_reg == diam_m1)
            begin
                dxi_reg     <= '0;
                dyi_reg     <= dyi_reg + KB'(1);
                cur_row_reg <= cur_row_reg + RW'(1);
                cur_col_reg <= col_start;
                row_ptr_reg <= next_row_ptr;
                ptr_reg     <= next_row_ptr;
            end
            else
            begin
                dxi_reg     <= dxi_reg + KB'(1);
                cur_col_reg <= cur_col_reg + CW'(1);
                ptr_reg     <= (int'(ptr_reg) == LS_DEPTH - 1) ? '0 : ptr_reg + LA'(1);
            end
        end
    end

    // Line store: one write port, one registered read port
    logic [23:0] ls_mem [LS_DEPTH];
    logic [23:0] ls_q;

    always_ff @(posedge clk)
    begin
        if (is_pixel)
        begin
            ls_mem[wr_addr_reg] <= {in_data.blue_in, in_data.green_in, in_data.red_in};
        end
        ls_q <= ls_mem[ptr_reg];
    end

    // Weight table with per-entry valid bits (unwritten reads as zero)
    logic [WEIGHT_BITS-1:0] wt_mem [KSIZE];
    logic [WEIGHT_BITS-1:0] wt_q;
    logic [KSIZE-1:0]       wt_vld_reg;
    logic                   wt_vld_q;
    logic                   wt_we;
    logic [KA-1:0]          wt_waddr;

    assign wt_we    = is_weight && (int'(in_data.weight_index) < KSIZE);
    assign wt_waddr = KA'(in_data.weight_index);

    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            wt_mem[wt_waddr] <= WEIGHT_BITS'(in_data.weight_value);
        end
        wt_q     <= wt_mem[widx_reg];
        wt_vld_q <= wt_vld_reg[widx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_vld_reg <= '0;
        end
        else if (wt_we)
        begin
            wt_vld_reg[wt_waddr] <= 1'b1;
        end
    end

    // Read pipeline tags
    logic vld_d_reg, inf_d_reg, ctr_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= 1'b0;
            inf_d_reg <= 1'b0;
            ctr_d_reg <= 1'b0;
        end
        else
        begin
            vld_d_reg <= cmd.scan_step;
            inf_d_reg <= in_frame;
            ctr_d_reg <= is_centre;
        end
    end

    // MAC and restoring divider (accumulator doubles as remainder)
    logic [ACC_W-1:0]       acc_reg [3];
    logic [7:0]             quo_reg [3];
    logic [SUM_W-1:0]       wsum_reg;
    logic [23:0]            centre_reg;
    logic [2:0]             div_cnt_reg;
    logic [WEIGHT_BITS-1:0] wt_eff;
    logic [PRW-1:0]         prod [3];
    logic [ACC_W:0]         trial [3];
    logic [ACC_W:0]         dsr;

    assign wt_eff = wt_vld_q ? wt_q : '0;
    assign dsr    = (ACC_W + 1)'(wsum_reg) << div_cnt_reg;
    assign status.div_last = (div_cnt_reg == 3'd0);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod[c]  = PRW'(ls_q[8*c +: 8]) * PRW'(wt_eff);
            trial[c] = {1'b0, acc_reg[c]} - dsr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            wsum_reg <= '0;
            for (int c = 0; c < 3; c++)
            begin
                acc_reg[c] <= '0;
                quo_reg[c] <= '0;
            end
        end
        else if (vld_d_reg)
        begin
            if (ctr_d_reg)
                centre_reg <= ls_q;
            if (inf_d_reg)
            begin
                wsum_reg <= wsum_reg + SUM_W'(wt_eff);
                for (int c = 0; c < 3; c++)
                    acc_reg[c] <= acc_reg[c] + ACC_W'(prod[c]);
            end
        end
        else if (cmd.div_step)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!trial[c][ACC_W])
                begin
                    acc_reg[c]              <= trial[c][ACC_W-1:0];
                    quo_reg[c][div_cnt_reg] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= 3'd7;
        else if (cmd.scan_init)
            div_cnt_reg <= 3'd7;
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg - 3'd1;
    end

    // Output register
    logic      out_valid_reg;
    out_item_t out_data_reg;
    logic      zero_sum;

    assign zero_sum        = (wsum_reg == '0);
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg.red_out   <= zero_sum ? centre_reg[7:0]   : quo_reg[0];
            out_data_reg.green_out <= zero_sum ? centre_reg[15:8]  : quo_reg[1];
            out_data_reg.blue_out  <= zero_sum ? centre_reg[23:16] : quo_reg[2];
            out_data_reg.out_row   <= out_row_reg;
            out_data_reg.out_col   <= 10'(out_col_reg);
            out_data_reg.frame_end <= (13'(out_row_reg) == h_eff - 13'd1) &&
                                      (out_col_reg == w_eff - WB'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### src/gaussian_blur_edge_renormalized_unit.sv
// Weight loads, non-emitting pixels and idle drains are taken without leaving idle.
// An item that produces a result goes through accept, one window tap per cycle
// through the single line-store read port, one flush, eight divider steps and
// output register load (held while a stalled result still sits there).
// Output lags input R*W+R pixels. Reset (rst_n, async low) clears counters,
// config to defaults and weight valid bits; the line store is not cleared.
`include "assert_macros.svh"

module gaussian_blur_edge_renormalized_unit
    import gber_pkg::*;
#(
    parameter int MAX_RADIUS  = MAX_RADIUS_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    gber_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    gber_dp #(
        .MAX_RADIUS  (MAX_RADIUS),
        .MAX_WIDTH   (MAX_WIDTH),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // An emit command is always followed by a valid result
    `ASSERT_NEXT(a_emit_sets_valid, cmd.emit, out_valid)
    // Emit never overwrites a result that is still held
    `ASSERT_IMPL(a_emit_slot_free, cmd.emit, !out_valid || !out_stall)
    // No input transfer while the window scan runs
    `ASSERT_IMPL(a_no_accept_in_scan, cmd.scan_step, in_stall)

endmodule

### sim/gaussian_blur_edge_renormalized_unit_tb.sv
// Testbench for the edge-renormalized blur unit: random and directed streams,
// checked against a blur predictor held in a small scoreboard class.
// Depends on gber_pkg and the gaussian_blur_edge_renormalized_unit RTL.
module gaussian_blur_edge_renormalized_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gber_pkg::*;

    localparam int KDIM       = 2 * MAX_RADIUS_DEF + 1;
    localparam int KSIZE      = KDIM * KDIM;
    localparam int RING_DEPTH = KDIM * MAX_WIDTH_DEF;
    localparam int SETTLE     = 200;
    localparam int ITEM_W     = $bits(in_item_t);
    localparam longint CYCLE_LIMIT = 3000000;

    // Operation code with no meaning, must be ignored
    localparam logic [1:0] OP_UNKNOWN = 2'd3;

    // Blur predictor with its own weights, ring of pixels and stream counters
    class blur_scoreboard;
        bit [15:0]   weights[KSIZE];
        bit [23:0]   ring[RING_DEPTH];
        int unsigned width_reg, height_reg, radius_reg;
        int unsigned in_row, in_col, pix_row, pix_col;
        int unsigned wr_addr, rd_addr, pending;
        out_item_t   blur_q[$];
        int          mismatches;

        function void reset_state();
            foreach (weights[i]) weights[i] = '0;
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            radius_reg = RADIUS_RST;
            clear_stream();
            mismatches = 0;
        endfunction

        function void clear_stream();
            in_row = 0; in_col = 0; pix_row = 0; pix_col = 0;
            wr_addr = 0; rd_addr = 0; pending = 0;
        endfunction

        function int unsigned eff_w();
            if (width_reg < 1) return 1;
            if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return width_reg;
        endfunction

        function int unsigned eff_h();
            if (height_reg < 1) return 1;
            if (height_reg > ROW_LIMIT) return ROW_LIMIT;
            return height_reg;
        endfunction

        function int unsigned eff_r();
            return (radius_reg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_reg;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_WIDTH:  width_reg  = val[10:0];
                CFG_HEIGHT: height_reg = val[12:0];
                CFG_RADIUS: radius_reg = val[2:0];
                default:    return;
            endcase
            clear_stream();
        endfunction

        // Renormalized window sum for the oldest pending pixel
        function void blur_pixel();
            int w, h, r, diam, dy, dx, row, col, a;
            longint unsigned acc[3];
            longint unsigned wsum;
            bit [23:0] pix, centre;
            bit [15:0] wt;
            out_item_t res;
            w = eff_w(); h = eff_h(); r = eff_r();
            diam = 2 * r + 1;
            acc[0] = 0; acc[1] = 0; acc[2] = 0; wsum = 0;
            centre = ring[rd_addr];
            for (int yi = 0; yi < diam; yi++) begin
                dy = yi - r;
                row = int'(pix_row) + dy;
                if (row < 0 || row >= h) continue;
                for (int xi = 0; xi < diam; xi++) begin
                    dx = xi - r;
                    col = int'(pix_col) + dx;
                    if (col < 0 || col >= w) continue;
                    a = int'(rd_addr) + dy * w + dx;
                    if (a < 0) a += RING_DEPTH;
                    a = a % RING_DEPTH;
                    pix = ring[a];
                    wt = weights[yi * diam + xi];
                    for (int c = 0; c < 3; c++)
                        acc[c] += longint'(pix[8*c +: 8]) * longint'(wt);
                    wsum += wt;
                end
            end
            res.red_out   = wsum != 0 ? 8'(acc[0] / wsum) : centre[7:0];
            res.green_out = wsum != 0 ? 8'(acc[1] / wsum) : centre[15:8];
            res.blue_out  = wsum != 0 ? 8'(acc[2] / wsum) : centre[23:16];
            res.out_row   = 12'(pix_row);
            res.out_col   = 10'(pix_col);
            res.frame_end = (pix_row == h - 1 && pix_col == w - 1);
            blur_q.push_back(res);
            rd_addr = (rd_addr + 1) % RING_DEPTH;
            pix_col++;
            if (pix_col >= w) begin
                pix_col = 0;
                pix_row++;
                if (pix_row >= h) pix_row = 0;
            end
            pending--;
        endfunction

        // Accepted input transfer
        function void note_input(in_item_t it);
            int unsigned w, r;
            w = eff_w(); r = eff_r();
            case (it.operation)
                OP_WEIGHT: if (it.weight_index < KSIZE) weights[it.weight_index] = it.weight_value;
                OP_PIXEL: begin
                    ring[wr_addr] = {it.blue_in, it.green_in, it.red_in};
                    wr_addr = (wr_addr + 1) % RING_DEPTH;
                    in_col++;
                    if (in_col >= w) begin
                        in_col = 0;
                        in_row++;
                        if (in_row >= eff_h()) in_row = 0;
                    end
                    pending++;
                    if (pending > r * w + r) blur_pixel();
                end
                OP_DRAIN: if (pending > 0) blur_pixel();
                default: ;
            endcase
        endfunction

        // Accepted output transfer
        function void check_result(out_item_t got);
            out_item_t want;
            if (blur_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = blur_q.pop_front();
            if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                got.blue_out !== want.blue_out || got.out_row !== want.out_row ||
                got.out_col !== want.out_col || got.frame_end !== want.frame_end) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p actual %p", want, got);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;
    logic      cfg_write;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    blur_scoreboard sb;
    bit     calm;
    int     hold_cycles;
    longint cycles;

    gaussian_blur_edge_renormalized_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: random stall, long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) sb.check_result(out_data);
            @(negedge clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_stall = 1'b1;
            end else
                out_stall = !calm && ($urandom_range(0, 99) < 21);
        end
    end

    // Offer one item until its transfer; called and returns at a falling edge.
    // Idle gaps only come before the item is offered; once offered it is held.
    task automatic send(in_item_t it);
        bit done;
        bit offered;
        done = 0;
        offered = 0;
        while (!done) begin
            if (!offered && !calm && $urandom_range(0, 99) < 21) begin
                in_valid = 1'b0;
                @(negedge clk);
            end else begin
                offered  = 1;
                in_valid = 1'b1;
                in_data  = it;
                @(posedge clk);
                if (!in_stall) begin
                    sb.note_input(it);
                    done = 1;
                end
                @(negedge clk);
            end
        end
    endtask

    // Sender pause until every result has come, then settle
    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.blur_q.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic configure(int w, int h, int r);
        wait_idle();
        write_reg(CFG_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_RADIUS, CFG_DATA_W'(r));
    endtask

    function automatic in_item_t make_item(logic [1:0] op);
        in_item_t it;
        it = ITEM_W'({$urandom, $urandom});
        it.operation = op;
        return it;
    endfunction

    task automatic send_weight(int idx, int val);
        in_item_t it;
        it = make_item(OP_WEIGHT);
        it.weight_index = 7'(idx);
        it.weight_value = 16'(val);
        send(it);
    endtask

    task automatic send_pixel(int rgb);
        in_item_t it;
        it = make_item(OP_PIXEL);
        {it.blue_in, it.green_in, it.red_in} = 24'(rgb);
        send(it);
    endtask

    // Complete the current frame, then flush pending pixels
    task automatic close_frame();
        while (sb.in_row != 0 || sb.in_col != 0) send(make_item(OP_PIXEL));
        while (sb.pending > 0) send(make_item(OP_DRAIN));
    endtask

    // Mostly raster pixels, with weight loads, drains at frame ends and noise
    task automatic random_phase(int n, bit finish);
        int sel, diam;
        in_item_t it;
        diam = 2 * sb.eff_r() + 1;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                it = make_item(OP_WEIGHT);
                it.weight_index = ($urandom_range(0, 9) == 0) ? 7'($urandom)
                                : 7'($urandom_range(0, diam * diam - 1));
                case ($urandom_range(0, 5))
                    0: it.weight_value = 16'h0000;
                    1: it.weight_value = 16'hFFFF;
                    default: ;
                endcase
                send(it);
            end else if (sel < 11)
                send(make_item(OP_UNKNOWN));
            else if (sel < 18 && sb.in_row == 0 && sb.in_col == 0)
                send(make_item(OP_DRAIN));
            else
                send(make_item(OP_PIXEL));
        end
        if (finish) close_frame();
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        calm = 0; hold_cycles = 0; cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset defaults: table edges, ignored loads, unknown op, empty drain
        send_weight(0, 16'hFFFF);
        send_weight(80, 1);
        send_weight(81, 16'h1234);
        send_weight(127, 16'hFFFF);
        send(make_item(OP_UNKNOWN));
        send(make_item(OP_DRAIN));

        // Zero weight sum passes the centre pixel through
        configure(3, 2, 1);
        send_weight(0, 0);
        send_pixel(24'h000000);
        send_pixel(24'hFFFFFF);
        send_pixel(24'h55AA55);
        send_pixel(24'hAA55AA);
        send_pixel(24'h0F0FF0);
        send_pixel(24'hF0F00F);
        close_frame();
        // Weighted window with edge renormalization
        send_weight(4, 16'hFFFF);
        send_weight(0, 1);
        send_weight(8, 16'h8000);
        for (int i = 0; i < 6; i++) send_pixel($urandom);
        close_frame();

        // Random phases over several settings, extremes among them
        configure(1, 1, 0);
        random_phase(50, 1);
        configure(4, 3, 1);
        random_phase(70, 1);
        configure(5, 4, 2);
        calm = 1;
        random_phase(50, 1);
        calm = 0;
        configure(3, 2, 4);
        hold_cycles = 600;
        random_phase(60, 1);
        configure(0, 0, 7);
        random_phase(40, 1);
        configure(2047, 1, 0);
        random_phase(20, 1);
        configure(2, 8191, 1);
        random_phase(60, 0);
        configure(6, 5, 3);
        random_phase(70, 1);

        wait_idle();
        if (sb.mismatches == 0 && sb.blur_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/gber_pkg.sv
src/gber_ctrl.sv
src/gber_dp.sv
src/gaussian_blur_edge_renormalized_unit.sv
sim/gaussian_blur_edge_renormalized_unit_tb.sv
